// ===== design/ght_pkg.sv =====
// Package for the gyro heading tracker: field widths, reset values of the
// control registers, opcode, report and register index codes.
// Depends on nothing; imported by gyro_heading_tracker_unit and its testbench.
package ght_pkg;

   // Defaults for the top level parameters.
   localparam int ACC_BITS_DEFAULT    = 32;
   localparam int SAMPLE_BITS_DEFAULT = 10;

   // Fixed field widths.
   localparam int OFFSET_BITS   = 10;
   localparam int DEADBAND_BITS = 6;
   localparam int SCALE_BITS    = 16;
   localparam int WINDOW_BITS   = 8;
   localparam int HEADING_BITS  = 9;
   localparam int BOUND_BITS    = 11;
   localparam int OPCODE_BITS   = 2;
   localparam int KIND_BITS     = 2;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam int RSP_DATA_BITS  = 16;

   // Fractional bits of the counts-per-degree scale.
   localparam int SCALE_FRAC_BITS = 8;

   // Degrees in one turn and the window code that stops monitoring.
   localparam logic [HEADING_BITS:0]  FULL_TURN = 10'd360;
   localparam logic [WINDOW_BITS-1:0] STOP_CODE = 8'h30;

   // Register values after reset.
   localparam logic [OFFSET_BITS-1:0]   RATE_OFFSET_RESET = 10'd512;
   localparam logic [DEADBAND_BITS-1:0] DEADBAND_RESET    = 6'd6;
   localparam logic [SCALE_BITS-1:0]    SCALE_RESET       = 16'd256;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_SAMPLE  = 2'd0,
      OP_ZERO    = 2'd1,
      OP_READ    = 2'd2,
      OP_MONITOR = 2'd3
   } opcode_type;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_HEADING = 2'd0,
      KIND_ABOVE   = 2'd1,
      KIND_BELOW   = 2'd2
   } kind_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_RATE_OFFSET = 2'd0,
      REG_DEADBAND    = 2'd1,
      REG_SCALE       = 2'd2
   } reg_index_type;

endpackage

// ===== design/gyro_heading_tracker_unit.sv =====
// Gyro heading tracker: rate integration with deadband, bit-serial heading
// divider with a running modulo-360 remainder, and bound monitoring.
// Depends on ght_pkg.
//
// Usage. Requests arrive on the req_ stream: tuser carries the opcode
// (sample, zero, read, monitor) and tdata the rate sample and window byte.
// Results leave on the rsp_ stream: tuser carries the report kind and tdata
// the wrapped heading. Control registers are written on the csr_ channel,
// which is always ready; write them only while the block is idle.
// A sample with monitoring off, a zero request and a stop-monitoring
// request finish in the cycle they are accepted, so the next request may
// follow at once. A read, a monitor capture and a sample with monitoring on
// need the heading, which the serial divider produces one quotient bit per
// cycle. Such a request passes through the load, divide and finish steps,
// and the block accepts no new request until it is back in idle; the
// finish step writes a read result to the output register.
// The result sits in an output register; the block keeps accepting requests
// while it waits, and only the finish step of a later heading request holds
// until that register has been taken by the receiver.
// Synchronous reset clears the accumulator, monitoring state and bounds,
// restores the register defaults and drops any pending result.
module gyro_heading_tracker_unit
   import ght_pkg::*;
#(
   parameter int ACC_BITS    = ACC_BITS_DEFAULT,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
   localparam int REQ_DATA_BITS = ((SAMPLE_BITS + WINDOW_BITS + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // From bit 0: rate_sample [SAMPLE_BITS], window_byte [8], zero fill.
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,
   // From bit 0: opcode [2].
   input  logic [OPCODE_BITS-1:0]    req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // From bit 0: heading_deg [9], zero fill.
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,
   // From bit 0: report_kind [2].
   output logic [KIND_BITS-1:0]      rsp_tuser,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   // Signed difference of sample and offset, and the width of the sum.
   localparam int DIFF_BITS = ((SAMPLE_BITS > OFFSET_BITS) ? SAMPLE_BITS : OFFSET_BITS) + 1;
   localparam int SUM_BITS  = (ACC_BITS > DIFF_BITS) ? ACC_BITS : DIFF_BITS;
   // Dividend is |acc| shifted left by the scale's fraction bits.
   localparam int DIV_BITS  = ACC_BITS + SCALE_FRAC_BITS;
   localparam int CNT_BITS  = $clog2(DIV_BITS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type                    state_ff, state_in;
   logic signed [ACC_BITS-1:0]   acc_ff, acc_in;
   logic                         monitor_ff, monitor_in;
   logic signed [BOUND_BITS-1:0] upper_ff, upper_in;
   logic signed [BOUND_BITS-1:0] lower_ff, lower_in;
   logic [OFFSET_BITS-1:0]       offset_ff, offset_in;
   logic [DEADBAND_BITS-1:0]     deadband_ff, deadband_in;
   logic [SCALE_BITS-1:0]        scale_ff, scale_in;
   opcode_type                   op_ff, op_in;
   logic [WINDOW_BITS-1:0]       window_ff, window_in;
   logic                         neg_ff, neg_in;
   logic [DIV_BITS-1:0]          dividend_ff, dividend_in;
   logic [SCALE_BITS-1:0]        rem_ff, rem_in;
   logic [HEADING_BITS-1:0]      turn_ff, turn_in;
   logic [CNT_BITS-1:0]          count_ff, count_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   kind_type                     rsp_kind_ff, rsp_kind_in;
   logic [HEADING_BITS-1:0]      rsp_heading_ff, rsp_heading_in;

   logic                         req_accept;
   logic [SAMPLE_BITS-1:0]       req_sample;
   logic [WINDOW_BITS-1:0]       req_window;
   opcode_type                   req_op;
   logic signed [DIFF_BITS-1:0]  diff;
   logic [DIFF_BITS-1:0]         diff_mag;
   logic signed [SUM_BITS-1:0]   acc_sum;
   logic [ACC_BITS-1:0]          acc_mag;
   logic [SCALE_BITS-1:0]        scale_eff;
   logic [SCALE_BITS:0]          trial;
   logic                         qbit;
   logic [HEADING_BITS:0]        turn_twice;
   logic signed [BOUND_BITS-1:0] head_signed;
   logic [HEADING_BITS-1:0]      head_wrapped;
   logic signed [BOUND_BITS-1:0] window_ext;
   logic                         out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_sample = req_tdata[SAMPLE_BITS-1:0];
   assign req_window = req_tdata[SAMPLE_BITS +: WINDOW_BITS];
   assign req_op     = opcode_type'(req_tuser);
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS - HEADING_BITS){1'b0}}, rsp_heading_ff};
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Rate difference, its magnitude, and the wrapped accumulator sum.
   assign diff     = $signed(DIFF_BITS'(req_sample) - DIFF_BITS'(offset_ff));
   assign diff_mag = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);
   assign acc_sum  = SUM_BITS'(acc_ff) + SUM_BITS'(diff);
   assign acc_mag  = acc_ff[ACC_BITS-1] ? ACC_BITS'(-acc_ff) : ACC_BITS'(acc_ff);

   // One restoring division step per cycle. The quotient bits come out most
   // significant first, so the remainder modulo 360 is kept alongside.
   assign scale_eff  = (scale_ff == '0) ? SCALE_BITS'(1) : scale_ff;
   assign trial      = {rem_ff, dividend_ff[DIV_BITS-1]};
   assign qbit       = (trial >= {1'b0, scale_eff});
   assign turn_twice = {turn_ff, qbit};

   // Heading with the sign of the accumulator, and wrapped into 0..359.
   assign head_signed  = neg_ff ? -$signed(BOUND_BITS'(turn_ff))
                                :  $signed(BOUND_BITS'(turn_ff));
   assign head_wrapped = (neg_ff && (turn_ff != '0))
                         ? HEADING_BITS'(FULL_TURN - (HEADING_BITS + 1)'(turn_ff))
                         : turn_ff;
   assign window_ext   = $signed(BOUND_BITS'(window_ff));

   always_comb begin
      state_in       = state_ff;
      acc_in         = acc_ff;
      monitor_in     = monitor_ff;
      upper_in       = upper_ff;
      lower_in       = lower_ff;
      offset_in      = offset_ff;
      deadband_in    = deadband_ff;
      scale_in       = scale_ff;
      op_in          = op_ff;
      window_in      = window_ff;
      neg_in         = neg_ff;
      dividend_in    = dividend_ff;
      rem_in         = rem_ff;
      turn_in        = turn_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_heading_in = rsp_heading_ff;

      if (csr_valid) begin
         if (csr_index == REG_RATE_OFFSET) begin
            offset_in = csr_data[OFFSET_BITS-1:0];
         end else if (csr_index == REG_DEADBAND) begin
            deadband_in = csr_data[DEADBAND_BITS-1:0];
         end else if (csr_index == REG_SCALE) begin
            scale_in = csr_data[SCALE_BITS-1:0];
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in     = req_op;
               window_in = req_window;
               unique case (req_op)
                  OP_SAMPLE: begin
                     if (diff_mag > DIFF_BITS'(deadband_ff)) begin
                        acc_in = acc_sum[ACC_BITS-1:0];
                     end
                     if (monitor_ff) begin
                        state_in = ST_LOAD;
                     end
                  end
                  OP_ZERO: begin
                     acc_in = '0;
                  end
                  OP_READ: begin
                     state_in = ST_LOAD;
                  end
                  OP_MONITOR: begin
                     if (req_window == STOP_CODE) begin
                        monitor_in = 1'b0;
                     end else begin
                        state_in = ST_LOAD;
                     end
                  end
               endcase
            end
         end
         ST_LOAD: begin
            neg_in      = acc_ff[ACC_BITS-1];
            dividend_in = {acc_mag, {SCALE_FRAC_BITS{1'b0}}};
            rem_in      = '0;
            turn_in     = '0;
            count_in    = CNT_BITS'(DIV_BITS - 1);
            state_in    = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            rem_in      = qbit ? SCALE_BITS'(trial - {1'b0, scale_eff})
                               : SCALE_BITS'(trial);
            turn_in     = (turn_twice >= FULL_TURN)
                          ? HEADING_BITS'(turn_twice - FULL_TURN)
                          : HEADING_BITS'(turn_twice);
            dividend_in = {dividend_ff[DIV_BITS-2:0], 1'b0};
            count_in    = count_ff - CNT_BITS'(1);
            if (count_ff == '0) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Hold here until the output register is free for a result.
            if (out_free) begin
               state_in = ST_IDLE;
               unique case (op_ff)
                  OP_SAMPLE: begin
                     if (head_signed > upper_ff) begin
                        monitor_in     = 1'b0;
                        rsp_valid_in   = 1'b1;
                        rsp_kind_in    = KIND_ABOVE;
                        rsp_heading_in = '0;
                     end else if (head_signed < lower_ff) begin
                        monitor_in     = 1'b0;
                        rsp_valid_in   = 1'b1;
                        rsp_kind_in    = KIND_BELOW;
                        rsp_heading_in = '0;
                     end
                  end
                  OP_ZERO: begin
                  end
                  OP_READ: begin
                     rsp_valid_in   = 1'b1;
                     rsp_kind_in    = KIND_HEADING;
                     rsp_heading_in = head_wrapped;
                  end
                  OP_MONITOR: begin
                     upper_in   = head_signed + window_ext;
                     lower_in   = head_signed - window_ext;
                     monitor_in = 1'b1;
                  end
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         monitor_ff   <= 1'b0;
         upper_ff     <= '0;
         lower_ff     <= '0;
         offset_ff    <= RATE_OFFSET_RESET;
         deadband_ff  <= DEADBAND_RESET;
         scale_ff     <= SCALE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         monitor_ff   <= monitor_in;
         upper_ff     <= upper_in;
         lower_ff     <= lower_in;
         offset_ff    <= offset_in;
         deadband_ff  <= deadband_in;
         scale_ff     <= scale_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      window_ff      <= window_in;
      neg_ff         <= neg_in;
      dividend_ff    <= dividend_in;
      rem_ff         <= rem_in;
      turn_ff        <= turn_in;
      count_ff       <= count_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_heading_ff <= rsp_heading_in;
   end

`ifndef SYNTHESIS
   // A zero request leaves a cleared accumulator behind it.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_tuser == OP_ZERO)) |=> (acc_ff == '0))
      else $error("accumulator not cleared by zero request");

   // The partial remainder always stays below the divisor.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (rem_ff < scale_eff))
      else $error("divider remainder reached the divisor");

   // The running modulo-360 remainder never reaches a full turn.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (turn_ff < HEADING_BITS'(FULL_TURN)))
      else $error("heading remainder out of range");

   // A finished sample check leaves monitoring off or the heading in bounds.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && op_ff == OP_SAMPLE && out_free)
      |=> (!monitor_ff || !rsp_valid_ff || rsp_kind_ff == KIND_HEADING))
      else $error("monitoring still active after a bound report");

   // A heading report always carries a wrapped heading.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_HEADING)
      |-> (rsp_heading_ff < HEADING_BITS'(FULL_TURN)))
      else $error("reported heading outside 0..359");
`endif

endmodule

// ===== sim/gyro_heading_tracker_unit_tb.sv =====
// Self-checking testbench for gyro_heading_tracker_unit: directed and random
// requests, a cycle-free heading predictor and a scoreboard of pending reports.
// Depends on ght_pkg and gyro_heading_tracker_unit.
module gyro_heading_tracker_unit_tb
   import ght_pkg::*;
();

   // Request tdata layout mirrors the block: rate sample, window byte, zero fill.
   localparam int SAMPLE_BITS   = SAMPLE_BITS_DEFAULT;
   localparam int REQ_BITS      = ((SAMPLE_BITS + WINDOW_BITS + 7) / 8) * 8;
   localparam int REQ_FILL_BITS = REQ_BITS - SAMPLE_BITS - WINDOW_BITS;
   localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;

   // A heading request keeps the block busy through its load, divide and finish
   // steps. A capture or an in-bounds sample may still be busy after the last
   // report arrives, so we wait this many cycles before writing or finishing.
   localparam int SETTLE_CYCLES = ACC_BITS_DEFAULT + 11 + 16;

   // Length of the long receiver hold-off that makes the block stall its input.
   localparam int HOLD_CYCLES = 600;

   typedef struct {
      kind_type                kind;
      logic [HEADING_BITS-1:0] deg;
   } heading_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_BITS-1:0]       req_tdata  = '0;
   opcode_type                req_tuser  = OP_SAMPLE;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic [KIND_BITS-1:0]      rsp_tuser;
   logic                      csr_valid  = 1'b0;
   logic                      csr_ready;
   reg_index_type             csr_index  = REG_RATE_OFFSET;
   logic [CSR_DATA_BITS-1:0]  csr_data   = '0;

   // Predictor state: a private copy of the registers and of the tracker.
   logic [OFFSET_BITS-1:0]          rate_offset;
   logic [DEADBAND_BITS-1:0]        deadband;
   logic [SCALE_BITS-1:0]           scale_q8;
   logic signed [ACC_BITS_DEFAULT-1:0] heading_acc;
   bit                              monitor_on;
   int                              upper_deg;
   int                              lower_deg;

   // Reports the predictor has produced and the block has not yet delivered.
   heading_report_type pending_reports[$];

   int  report_errors  = 0;
   int  send_idle_pct  = 0;
   int  recv_stall_pct = 0;
   bit  hold_go        = 1'b0;
   int  hold_left      = 0;

   gyro_heading_tracker_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Hard stop in case the block hangs; far beyond the slowest correct run.
   initial begin : watchdog
      #4_000_000;
      $display("FAILURE");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Heading predictor
   // ---------------------------------------------------------------------

   // The register state after reset; the tracker itself starts cleared.
   task automatic clear_tracker_state();
      rate_offset = RATE_OFFSET_RESET;
      deadband    = DEADBAND_RESET;
      scale_q8    = SCALE_RESET;
      heading_acc = '0;
      monitor_on  = 1'b0;
      upper_deg   = 0;
      lower_deg   = 0;
   endtask

   // Heading in -359..359: |acc|*256 divided by the Q8.8 scale, truncated,
   // then a truncated remainder by a full turn with the sign put back.
   // A scale of zero divides by one.
   function automatic int signed_heading();
      longint          acc_wide;
      longint unsigned mag;
      longint unsigned divisor;
      longint unsigned quotient;
      acc_wide = heading_acc;
      mag      = (acc_wide < 0) ? -acc_wide : acc_wide;
      divisor  = (scale_q8 == '0) ? 1 : scale_q8;
      quotient = ((mag << SCALE_FRAC_BITS) / divisor) % int'(FULL_TURN);
      return (acc_wide < 0) ? -int'(quotient) : int'(quotient);
   endfunction

   // Advances the predictor by one accepted request and queues the report it
   // causes, if any.
   function automatic void track_request(opcode_type op,
                                         logic [SAMPLE_BITS-1:0] sample,
                                         logic [WINDOW_BITS-1:0] window);
      int                 diff;
      int                 h;
      heading_report_type rpt;
      case (op)
         OP_SAMPLE: begin
            diff = int'(sample) - int'(rate_offset);
            if ((diff < 0 ? -diff : diff) > int'(deadband))
               heading_acc = heading_acc + diff;
            if (monitor_on) begin
               h = signed_heading();
               // The upper bound wins when both would apply.
               if (h > upper_deg || h < lower_deg) begin
                  monitor_on = 1'b0;
                  rpt.kind   = (h > upper_deg) ? KIND_ABOVE : KIND_BELOW;
                  rpt.deg    = '0;
                  pending_reports.push_back(rpt);
               end
            end
         end
         OP_ZERO: begin
            heading_acc = '0;
         end
         OP_READ: begin
            h = signed_heading();
            if (h < 0)
               h = h + int'(FULL_TURN);
            rpt.kind = KIND_HEADING;
            rpt.deg  = h[HEADING_BITS-1:0];
            pending_reports.push_back(rpt);
         end
         OP_MONITOR: begin
            if (window == STOP_CODE) begin
               monitor_on = 1'b0;
            end else begin
               h          = signed_heading();
               upper_deg  = h + int'(window);
               lower_deg  = h - int'(window);
               monitor_on = 1'b1;
            end
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------

   // Offers one request and returns at the edge where it was accepted. The
   // valid is left high, so that a following request goes out back to back;
   // whoever stops sending lowers it.
   task automatic send_request(opcode_type op, logic [SAMPLE_BITS-1:0] sample,
                               logic [WINDOW_BITS-1:0] window);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{REQ_FILL_BITS{1'b0}}, window, sample};
      do @(posedge clock); while (!req_tready);
      track_request(op, sample, window);
   endtask

   // Stops sending and waits until every queued report has been delivered and
   // the block has had time to finish any request that produces no report.
   task automatic settle_requests();
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write; the valid stays high for a following write.
   task automatic csr_write(reg_index_type idx, logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_RATE_OFFSET: rate_offset = value[OFFSET_BITS-1:0];
         REG_DEADBAND:    deadband    = value[DEADBAND_BITS-1:0];
         REG_SCALE:       scale_q8    = value[SCALE_BITS-1:0];
         default: ;
      endcase
   endtask

   // Writes all three registers; only called while the block is idle.
   task automatic apply_settings(logic [CSR_DATA_BITS-1:0] offset_word,
                                 logic [CSR_DATA_BITS-1:0] deadband_word,
                                 logic [CSR_DATA_BITS-1:0] scale_word);
      csr_write(REG_RATE_OFFSET, offset_word);
      csr_write(REG_DEADBAND, deadband_word);
      csr_write(REG_SCALE, scale_word);
      csr_valid <= 1'b0;
   endtask

   // Receiver: random stalls at the current rate, or a long hold-off counted
   // here once the test asks for it.
   always @(posedge clock) begin
      if (hold_go) begin
         hold_go    <= 1'b0;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Every delivered report is matched against the oldest pending one.
   always @(posedge clock) begin : check_reports
      heading_report_type rpt;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: unexpected report, kind %0d data 0x%0h", $time,
                     rsp_tuser, rsp_tdata);
            report_errors++;
         end else begin
            rpt = pending_reports.pop_front();
            if (rsp_tuser !== rpt.kind) begin
               $display("%0t: report kind expected %0d, actual %0d", $time,
                        rpt.kind, rsp_tuser);
               report_errors++;
            end
            if (rsp_tdata !== RSP_DATA_BITS'(rpt.deg)) begin
               $display("%0t: heading expected %0d, actual %0d", $time,
                        rpt.deg, rsp_tdata);
               report_errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Mostly samples near the zero-rate reading, where the deadband matters,
   // with rail values and uniform values mixed in.
   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      int v;
      case ($urandom_range(0, 3))
         0: v = $urandom_range(0, SAMPLE_MAX);
         1: v = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
         default: v = int'(rate_offset) + int'($urandom_range(0, 160)) - 80;
      endcase
      if (v < 0)
         v = 0;
      if (v > SAMPLE_MAX)
         v = SAMPLE_MAX;
      return v[SAMPLE_BITS-1:0];
   endfunction

   // A sample on one side of the zero-rate reading, so the heading drifts.
   function automatic logic [SAMPLE_BITS-1:0] pick_turn_sample(bit turn_up);
      int v;
      if (turn_up)
         v = $urandom_range(int'(rate_offset), SAMPLE_MAX);
      else
         v = $urandom_range(0, int'(rate_offset));
      return v[SAMPLE_BITS-1:0];
   endfunction

   function automatic logic [WINDOW_BITS-1:0] pick_window();
      case ($urandom_range(0, 9))
         0:       return STOP_CODE;
         1, 2, 3: return WINDOW_BITS'($urandom_range(0, 30));
         default: return WINDOW_BITS'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic opcode_type pick_opcode();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45)
         return OP_SAMPLE;
      else if (r < 50)
         return OP_ZERO;
      else if (r < 75)
         return OP_READ;
      else
         return OP_MONITOR;
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Every opcode at the reset settings: reads around zero, samples at the
   // edges of the deadband and at both rails, a capture with the smallest and
   // the largest window, exits past either bound, the stop code, and a clear.
   task automatic test_directed_opcodes();
      send_idle_pct = 0;
      send_request(OP_READ, '0, '0);
      send_request(OP_SAMPLE, 10'd518, 8'd0);
      send_request(OP_SAMPLE, 10'd506, 8'd0);
      send_request(OP_SAMPLE, 10'd519, 8'd0);
      send_request(OP_READ, '0, '0);
      send_request(OP_MONITOR, '0, 8'd0);
      send_request(OP_SAMPLE, 10'd1023, 8'd255);
      send_request(OP_MONITOR, 10'd1023, 8'd255);
      send_request(OP_SAMPLE, 10'd0, 8'd0);
      send_request(OP_SAMPLE, 10'd0, 8'd0);
      send_request(OP_READ, '0, '0);
      send_request(OP_MONITOR, '0, STOP_CODE);
      send_request(OP_MONITOR, '0, 8'd10);
      send_request(OP_MONITOR, '0, STOP_CODE);
      send_request(OP_SAMPLE, 10'd1023, 8'd0);
      send_request(OP_ZERO, 10'd1023, 8'd255);
      send_request(OP_READ, '0, '0);
      settle_requests();
   endtask

   // Register extremes: a zero scale (taken as one) with no offset and the
   // widest deadband, then the top offset, no deadband and the largest scale.
   task automatic test_register_extremes();
      apply_settings(16'd0, 16'd63, 16'd0);
      send_request(OP_SAMPLE, 10'd63, 8'd0);
      send_request(OP_SAMPLE, 10'd64, 8'd0);
      send_request(OP_READ, '0, '0);
      settle_requests();
      apply_settings(16'd1023, 16'd0, 16'hFFFF);
      send_request(OP_SAMPLE, 10'd1022, 8'd0);
      send_request(OP_READ, '0, '0);
      send_request(OP_SAMPLE, 10'd1023, 8'd0);
      send_request(OP_READ, '0, '0);
      settle_requests();
   endtask

   // The receiver holds off for a long stretch while heading requests keep
   // coming, so the output register fills and the block stalls its input.
   task automatic test_output_backpressure();
      int i;
      apply_settings(RATE_OFFSET_RESET, DEADBAND_RESET, SCALE_RESET);
      send_idle_pct = 0;
      hold_go <= 1'b1;
      for (i = 0; i < 24; i++) begin
         case (i % 3)
            0: send_request(OP_READ, pick_sample(), pick_window());
            1: send_request(OP_MONITOR, pick_sample(), WINDOW_BITS'($urandom_range(0, 40)));
            default: send_request(OP_SAMPLE, pick_sample(), pick_window());
         endcase
      end
      settle_requests();
   endtask

   // Random traffic at one idling setting. Part of it is shaped as a capture
   // with a narrow window followed by samples turning one way and a read,
   // which is what drives the heading across a bound. Now and then the
   // sender waits until every report has come back.
   task automatic test_random_traffic(int count, int idle_pct, int stall_pct);
      int sent;
      int run_len;
      bit turn_up;
      send_idle_pct  = idle_pct;
      recv_stall_pct <= stall_pct;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 99) < 15) begin
            run_len = $urandom_range(3, 8);
            turn_up = $urandom_range(0, 1);
            send_request(OP_MONITOR, pick_sample(), WINDOW_BITS'($urandom_range(0, 40)));
            repeat (run_len) send_request(OP_SAMPLE, pick_turn_sample(turn_up), pick_window());
            send_request(OP_READ, pick_sample(), pick_window());
            sent += run_len + 2;
         end else begin
            send_request(pick_opcode(), pick_sample(), pick_window());
            sent++;
         end
         if ($urandom_range(0, 99) < 2)
            settle_requests();
      end
      settle_requests();
   endtask

   // ---------------------------------------------------------------------
   // Sequence of the run
   // ---------------------------------------------------------------------
   initial begin
      clear_tracker_state();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_opcodes();
      test_register_extremes();
      test_output_backpressure();

      // Reset settings with no idling on either side.
      apply_settings(RATE_OFFSET_RESET, DEADBAND_RESET, SCALE_RESET);
      test_random_traffic(210, 0, 0);
      // Zero offset and deadband with the finest scale; the high bits of the offset
      // and deadband writes are set to show that only the register width is kept.
      apply_settings(16'hFC00, 16'hFFC0, 16'h0001);
      test_random_traffic(210, 75, 0);
      // Top offset, widest deadband, coarsest scale.
      apply_settings(16'h03FF, 16'h003F, 16'hFFFF);
      test_random_traffic(210, 0, 75);
      // Random settings, including fractional scales.
      apply_settings(CSR_DATA_BITS'($urandom()), CSR_DATA_BITS'($urandom()),
                     CSR_DATA_BITS'($urandom_range(1, 65535)));
      test_random_traffic(210, 26, 26);

      settle_requests();
      if (report_errors == 0 && pending_reports.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
